// File: rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Types and tables shared by the arithmetic decoder modules.
// ----------------------------------------------------------------------------
package cad_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_FEED   = 2'd1;
    localparam logic [1:0] OP_DECIDE = 2'd2;
    localparam logic [1:0] OP_BYPASS = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STARVED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    localparam logic [8:0] START_RANGE = 9'd510;
    localparam logic [6:0] START_BITS  = 7'd23;
    localparam int         WORD_BITS   = 32;
    localparam int         OFF_W       = 41;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] stream_word;
        logic [5:0]  ctx_state;
        logic        ctx_mps;
    } t_in_item;

    typedef struct packed {
        logic       bin_value;
        logic [5:0] next_ctx_state;
        logic       next_ctx_mps;
        logic [1:0] status;
    } t_out_item;

    // classified command handed from front to engine
    typedef struct packed {
        logic        is_start;
        logic        is_feed;
        logic        is_decide;
        logic        is_bypass;
        logic [31:0] word;
        logic [5:0]  st;
        logic        mps;
    } t_cmd;

    typedef struct packed {
        logic [8:0] range;
        logic [6:0] bits;
    } t_eng_status;

    localparam logic [7:0] LPS_RANGE [64][4] = '{
        '{128,176,208,240},'{128,167,197,227},'{128,158,187,216},'{123,150,178,205},
        '{116,142,169,195},'{111,135,160,185},'{105,128,152,175},'{100,122,144,166},
        '{95,116,137,158},'{90,110,130,150},'{85,104,123,142},'{81,99,117,135},
        '{77,94,111,128},'{73,89,105,122},'{69,85,100,116},'{66,80,95,110},
        '{62,76,90,104},'{59,72,86,99},'{56,69,81,94},'{53,65,77,89},
        '{51,62,73,85},'{48,59,69,80},'{46,56,66,76},'{43,53,63,72},
        '{41,50,59,69},'{39,48,56,65},'{37,45,54,62},'{35,43,51,59},
        '{33,41,48,56},'{32,39,46,53},'{30,37,43,50},'{29,35,41,48},
        '{27,33,39,45},'{26,31,37,43},'{24,30,35,41},'{23,28,33,39},
        '{22,27,32,37},'{21,26,30,35},'{20,24,29,33},'{19,23,27,31},
        '{18,22,26,30},'{17,21,25,28},'{16,20,23,27},'{15,19,22,25},
        '{14,18,21,24},'{14,17,20,23},'{13,16,19,22},'{12,15,18,21},
        '{12,14,17,20},'{11,14,16,19},'{11,13,15,18},'{10,12,15,17},
        '{10,12,14,16},'{9,11,13,15},'{9,11,12,14},'{8,10,12,14},
        '{8,9,11,13},'{7,9,11,12},'{7,9,10,12},'{7,8,10,11},
        '{6,8,9,11},'{6,7,9,10},'{6,7,8,9},'{2,2,2,2}
    };

    localparam logic [5:0] NEXT_ON_LPS [64] = '{
        0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,13,13,15,15,16,16,18,18,
        19,19,21,21,22,22,23,24,24,25,26,26,27,27,28,29,29,30,30,30,31,32,
        32,33,33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
    };

    // shifts needed to bring an lps range back to 256 or above
    function automatic logic [3:0] f_norm_shift(input logic [7:0] lps);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (lps[i]) begin
                n = 4'(8 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/cabac_arith_decoder_unit.sv
// ----------------------------------------------------------------------------
// cabac_arith_decoder_unit
// CABAC binary arithmetic decoder with an offset bit reservoir.
// ----------------------------------------------------------------------------
// channel   direction  handshake            word
// input     in         push / full          t_in_item
// result    out        pop / empty          t_out_item
//
// one item per cycle while the result queue has room; each word decodes in the
// engine as it leaves the input queue, and its result is registered into the result queue.
// the engine's offset compare and renormalization are combinational.
// input and result queues hold two words each; a stalled pop fills the
// result queue, then the input queue, then raises full.
// synchronous active-low reset empties both queues and resets the coder state.
// ----------------------------------------------------------------------------
module cabac_arith_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cad_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output cad_pkg::t_out_item o_result
);
    import cad_pkg::*;

    logic        cmd_valid;
    t_cmd        cmd;
    logic        out_full;
    logic        out_valid;
    logic        eng_fire;
    t_out_item   eng_result;
    t_eng_status eng_status;

    assign eng_fire = cmd_valid && !out_full;
    assign empty    = !out_valid;

    cad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (eng_fire),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    cad_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (eng_fire),
        .i_cmd    (cmd),
        .o_result (eng_result),
        .o_status (eng_status)
    );

    cad_fifo #(.WIDTH($bits(t_out_item))) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (eng_fire),
        .i_wdata (eng_result),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_valid (out_valid)
    );

    // range stays normalized
    a_range_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.range[8])
        else $error("coder range below 256");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.bits <= 7'd32)
        else $error("reservoir bit count out of bounds");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status != 2'd3))
        else $error("undefined status code");

    a_no_lost_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && !out_full) |=> !empty)
        else $error("decoded word missing from result queue");
endmodule

// File: rtl/cad_fifo.sv
// ----------------------------------------------------------------------------
// cad_fifo
// Two-entry queue with registered storage.
// ----------------------------------------------------------------------------
module cad_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_valid
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_fire = i_wr && !o_full;
    assign rd_fire = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_fire) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, wr_fire} - {1'b0, rd_fire};
        end
    end
endmodule

// File: rtl/cad_front.sv
// ----------------------------------------------------------------------------
// cad_front
// Input queue and operation decode feeding the engine.
// ----------------------------------------------------------------------------
module cad_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cad_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_take,
    output logic              o_valid,
    output cad_pkg::t_cmd     o_cmd
);
    import cad_pkg::*;

    t_in_item head;

    cad_fifo #(.WIDTH($bits(t_in_item))) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (i_item),
        .o_full  (o_full),
        .i_rd    (i_take),
        .o_rdata (head),
        .o_valid (o_valid)
    );

    always_comb begin
        o_cmd           = '0;
        o_cmd.word      = head.stream_word;
        o_cmd.st        = head.ctx_state;
        o_cmd.mps       = head.ctx_mps;
        case (head.operation)
            OP_START:  o_cmd.is_start  = 1'b1;
            OP_FEED:   o_cmd.is_feed   = 1'b1;
            OP_DECIDE: o_cmd.is_decide = 1'b1;
            OP_BYPASS: o_cmd.is_bypass = 1'b1;
            default:   o_cmd.is_bypass = 1'b1;
        endcase
    end
endmodule

// File: rtl/cad_engine.sv
// ----------------------------------------------------------------------------
// cad_engine
// Arithmetic decoding state and combinational bin decode.
// ----------------------------------------------------------------------------
module cad_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  cad_pkg::t_cmd        i_cmd,
    output cad_pkg::t_out_item   o_result,
    output cad_pkg::t_eng_status o_status
);
    import cad_pkg::*;

    logic [8:0]       r_range;
    logic [OFF_W-1:0] r_off;
    logic [6:0]       r_bits;
    logic [31:0]      r_spare;
    logic             r_spare_valid;

    logic [8:0]       n_range;
    logic [OFF_W-1:0] n_off;
    logic [6:0]       n_bits;
    logic             n_spare_valid;
    logic             spare_wr;

    logic [7:0]       lps;
    logic [8:0]       rng_mps;
    logic [OFF_W-1:0] bnd_d;
    logic             lps_hit;
    logic [3:0]       sh;
    logic [8:0]       rng_d;
    logic [OFF_W-1:0] off_d;
    logic signed [7:0] bits_s;
    logic             refill_d;

    logic             refill_b;
    logic [OFF_W-1:0] off_b;
    logic [5:0]       bits_b;
    logic [OFF_W-1:0] bnd_b;
    logic             hit_b;

    assign o_status.range = r_range;
    assign o_status.bits  = r_bits;

    // decision path
    always_comb begin
        lps     = LPS_RANGE[i_cmd.st][r_range[7:6]];
        rng_mps = r_range - {1'b0, lps};
        bnd_d   = {{(OFF_W-9){1'b0}}, rng_mps} << r_bits[5:0];
        lps_hit = (r_off >= bnd_d);
        if (lps_hit) begin
            sh    = f_norm_shift(lps);
            off_d = r_off - bnd_d;
            rng_d = 9'({1'b0, lps} << sh);
        end else begin
            off_d = r_off;
            if (!rng_mps[8]) begin
                sh    = 4'd1;
                rng_d = {rng_mps[7:0], 1'b0};
            end else begin
                sh    = 4'd0;
                rng_d = rng_mps;
            end
        end
        bits_s   = $signed({1'b0, r_bits}) - $signed({4'b0, sh});
        refill_d = (sh != 4'd0) && (bits_s <= 8'sd0);
    end

    // bypass path
    always_comb begin
        refill_b = (r_bits[5:0] == 6'd0);
        off_b    = refill_b ? {r_off[8:0], r_spare} : r_off;
        bits_b   = refill_b ? 6'(WORD_BITS - 1) : r_bits[5:0] - 6'd1;
        bnd_b    = {{(OFF_W-9){1'b0}}, r_range} << bits_b;
        hit_b    = (off_b >= bnd_b);
    end

    always_comb begin
        n_range       = r_range;
        n_off         = r_off;
        n_bits        = r_bits;
        n_spare_valid = r_spare_valid;
        spare_wr      = 1'b0;
        o_result      = '0;
        if (i_cmd.is_start) begin
            n_off         = {{(OFF_W-32){1'b0}}, i_cmd.word};
            n_bits        = START_BITS;
            n_range       = START_RANGE;
            n_spare_valid = 1'b0;
        end else if (i_cmd.is_feed) begin
            if (r_spare_valid) begin
                o_result.status = ST_DROPPED;
            end else begin
                spare_wr      = 1'b1;
                n_spare_valid = 1'b1;
            end
        end else if (i_cmd.is_decide) begin
            if (refill_d && !r_spare_valid) begin
                o_result.status         = ST_STARVED;
                o_result.next_ctx_state = i_cmd.st;
                o_result.next_ctx_mps   = i_cmd.mps;
            end else begin
                o_result.bin_value = i_cmd.mps ^ lps_hit;
                if (lps_hit) begin
                    o_result.next_ctx_state = NEXT_ON_LPS[i_cmd.st];
                    o_result.next_ctx_mps   = (i_cmd.st == 6'd0) ? !i_cmd.mps : i_cmd.mps;
                end else begin
                    o_result.next_ctx_state = (i_cmd.st >= 6'd62) ? i_cmd.st
                                                                  : i_cmd.st + 6'd1;
                    o_result.next_ctx_mps   = i_cmd.mps;
                end
                n_range = rng_d;
                if (refill_d) begin
                    n_off         = {off_d[8:0], r_spare};
                    n_bits        = 7'(bits_s + 8'sd32);
                    n_spare_valid = 1'b0;
                end else begin
                    n_off  = off_d;
                    n_bits = 7'(bits_s);
                end
            end
        end else begin
            if (refill_b && !r_spare_valid) begin
                o_result.status = ST_STARVED;
            end else begin
                o_result.bin_value = hit_b;
                n_off  = hit_b ? off_b - bnd_b : off_b;
                n_bits = {1'b0, bits_b};
                if (refill_b) begin
                    n_spare_valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && spare_wr) begin
            r_spare <= i_cmd.word;
        end
        if (!i_rst_n) begin
            r_range       <= START_RANGE;
            r_off         <= '0;
            r_bits        <= '0;
            r_spare_valid <= 1'b0;
        end else if (i_fire) begin
            r_range       <= n_range;
            r_off         <= n_off;
            r_bits        <= n_bits;
            r_spare_valid <= n_spare_valid;
        end
    end
endmodule
